/* rtl/wbkcs_pkg.sv */
package wbkcs_pkg;

    // Default chain geometry
    localparam int ROWS_DEF = 8;
    localparam int COLS_DEF = 16;

    // Register map, word index on the configuration port
    localparam logic [1:0] REG_SCAN_ENABLE    = 2'd0;
    localparam logic [1:0] REG_INVERTED_DRIVE = 2'd1;
    localparam logic [1:0] REG_EXTRA_PULLUP   = 2'd2;
    localparam logic [1:0] REG_SETTLE_TICKS   = 2'd3;

    localparam logic [7:0] SETTLE_TICKS_RST = 8'd2;

    typedef enum logic [1:0] {
        PH_FLUSH  = 2'd0,
        PH_SETTLE = 2'd1,
        PH_SAMPLE = 2'd2,
        PH_SHIFT  = 2'd3
    } phase_t;

    typedef struct packed {
        logic       scan_enable;
        logic       inverted_drive;
        logic       extra_pullup;
        logic [7:0] settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic        chain_clock;
        logic        drive_enable;
        logic        drive_level;
        logic        pull_down_select;
        logic        row_valid;
        logic [2:0]  row_index;
        logic [15:0] row_keys;
        logic        row_changed;
        logic        scan_done;
        logic        scan_changed;
    } result_t;

endpackage

/* rtl/walking_bit_key_chain_scanner_top.sv */
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_sense_level
// m_        out        m_valid/m_ready    m_chain_clock ... m_scan_changed (10 fields)
// APB       in/out     psel/penable/pready paddr, pwdata, prdata
//
// For each tick request the scan step runs in a single combinational pass from the scan
// state registers into a two-entry result buffer, so one request per cycle is accepted
// while results drain. s_ready drops only when both buffer entries are full.
// Reset (aresetn, synchronous, active low) returns to flush start, clears the stored
// rows and restores the register defaults (settle_ticks = 2, all else 0).
module walking_bit_key_chain_scanner_top
    import wbkcs_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Tick requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_sense_level,
    // Results
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_chain_clock,
    output logic        m_drive_enable,
    output logic        m_drive_level,
    output logic        m_pull_down_select,
    output logic        m_row_valid,
    output logic [2:0]  m_row_index,
    output logic [15:0] m_row_keys,
    output logic        m_row_changed,
    output logic        m_scan_done,
    output logic        m_scan_changed,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg_reg;
    result_t step_res;
    result_t out_res;
    logic    step;
    logic    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign step   = s_valid & s_ready;

    // Register file: write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_enable    <= 1'b0;
            cfg_reg.inverted_drive <= 1'b0;
            cfg_reg.extra_pullup   <= 1'b0;
            cfg_reg.settle_ticks   <= SETTLE_TICKS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SCAN_ENABLE:    cfg_reg.scan_enable    <= pwdata[0];
                REG_INVERTED_DRIVE: cfg_reg.inverted_drive <= pwdata[0];
                REG_EXTRA_PULLUP:   cfg_reg.extra_pullup   <= pwdata[0];
                REG_SETTLE_TICKS:   cfg_reg.settle_ticks   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Readback
    always_comb begin
        unique case (paddr[3:2])
            REG_SCAN_ENABLE:    prdata = {31'd0, cfg_reg.scan_enable};
            REG_INVERTED_DRIVE: prdata = {31'd0, cfg_reg.inverted_drive};
            REG_EXTRA_PULLUP:   prdata = {31'd0, cfg_reg.extra_pullup};
            REG_SETTLE_TICKS:   prdata = {24'd0, cfg_reg.settle_ticks};
            default:            prdata = '0;
        endcase
    end

    // Scan sequencer: advance one pin action per accepted request
    wbkcs_scan #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .sense_level (s_sense_level),
        .cfg         (cfg_reg),
        .res         (step_res)
    );

    // Result buffer: hold results while the sink stalls
    wbkcs_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (step),
        .push_data  (step_res),
        .push_ready (s_ready),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (out_res)
    );

    assign m_chain_clock      = out_res.chain_clock;
    assign m_drive_enable     = out_res.drive_enable;
    assign m_drive_level      = out_res.drive_level;
    assign m_pull_down_select = out_res.pull_down_select;
    assign m_row_valid        = out_res.row_valid;
    assign m_row_index        = out_res.row_index;
    assign m_row_keys         = out_res.row_keys;
    assign m_row_changed      = out_res.row_changed;
    assign m_scan_done        = out_res.scan_done;
    assign m_scan_changed     = out_res.scan_changed;

endmodule

/* rtl/wbkcs_scan.sv */
module wbkcs_scan
    import wbkcs_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  logic    sense_level,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int FW = $clog2(ROWS * COLS + 1);
    localparam logic [FW-1:0] FLUSH_LEN = FW'(ROWS * COLS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);

    phase_t            phase_reg, phase_next;
    logic [FW-1:0]     flush_count_reg, flush_count_next;
    logic [7:0]        settle_count_reg, settle_count_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [COLS-1:0]   acc_reg, acc_next;
    logic [COLS-1:0]   stored_reg [ROWS];
    logic              store_we;
    logic              any_change_reg, any_change_next;

    logic              off_level;
    logic [7:0]        settle_inc;
    logic [COLS-1:0]   acc_sampled;
    logic              last_col;
    logic              last_row;
    logic              row_differs;
    logic [31:0]       row_wide;
    logic [31:0]       bits_wide;

    assign off_level   = ~cfg.inverted_drive;
    assign settle_inc  = settle_count_reg + 8'd1;
    assign acc_sampled = acc_reg | ({{(COLS-1){1'b0}}, ~sense_level} << col_reg);
    assign last_col    = (col_reg == LAST_COL);
    assign last_row    = (row_reg == LAST_ROW);
    assign row_differs = (stored_reg[row_reg] != acc_sampled);
    assign row_wide    = 32'(row_reg);
    assign bits_wide   = 32'(acc_sampled);

    // Next state
    always_comb begin
        phase_next        = phase_reg;
        flush_count_next  = flush_count_reg;
        settle_count_next = settle_count_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        acc_next          = acc_reg;
        any_change_next   = any_change_reg;
        store_we          = 1'b0;
        if (!cfg.scan_enable) begin
            phase_next        = PH_FLUSH;
            flush_count_next  = '0;
            settle_count_next = '0;
            row_next          = '0;
            col_next          = '0;
            acc_next          = '0;
        end else begin
            unique case (phase_reg)
                PH_FLUSH: begin
                    if (flush_count_reg < FLUSH_LEN) begin
                        flush_count_next = flush_count_reg + FW'(1);
                    end else begin
                        flush_count_next  = '0;
                        settle_count_next = '0;
                        phase_next = (cfg.settle_ticks != 8'd0) ? PH_SETTLE : PH_SAMPLE;
                    end
                end
                PH_SETTLE: begin
                    settle_count_next = settle_inc;
                    if (settle_inc >= cfg.settle_ticks) begin
                        settle_count_next = '0;
                        phase_next        = PH_SAMPLE;
                    end
                end
                PH_SAMPLE: begin
                    phase_next = PH_SHIFT;
                    if (last_col) begin
                        store_we = row_differs;
                        if (row_differs) begin
                            any_change_next = 1'b1;
                        end
                        acc_next = '0;
                        col_next = '0;
                        if (last_row) begin
                            any_change_next = 1'b0;
                            row_next        = '0;
                        end else begin
                            row_next = row_reg + RW'(1);
                        end
                    end else begin
                        acc_next = acc_sampled;
                        col_next = col_reg + CW'(1);
                    end
                end
                PH_SHIFT: begin
                    settle_count_next = '0;
                    if (row_reg == '0 && col_reg == '0) begin
                        phase_next        = PH_FLUSH;
                        flush_count_next  = '0;
                        acc_next          = '0;
                    end else begin
                        phase_next = (cfg.settle_ticks != 8'd0) ? PH_SETTLE : PH_SAMPLE;
                    end
                end
                default: phase_next = PH_FLUSH;
            endcase
        end
    end

    // Outputs of the step
    always_comb begin
        res                  = '0;
        res.drive_enable     = 1'b1;
        res.drive_level      = off_level;
        res.pull_down_select = cfg.extra_pullup;
        if (cfg.scan_enable) begin
            unique case (phase_reg)
                PH_FLUSH: begin
                    res.chain_clock = 1'b1;
                    if (flush_count_reg >= FLUSH_LEN) begin
                        res.drive_level = ~off_level;
                    end
                end
                PH_SETTLE: begin
                    res.drive_enable = 1'b0;
                    res.drive_level  = 1'b0;
                end
                PH_SAMPLE: begin
                    res.drive_enable = 1'b0;
                    res.drive_level  = 1'b0;
                    if (last_col) begin
                        res.row_valid    = 1'b1;
                        res.row_index    = row_wide[2:0];
                        res.row_keys     = bits_wide[15:0];
                        res.row_changed  = row_differs;
                        res.scan_done    = last_row;
                        res.scan_changed = last_row & (any_change_reg | row_differs);
                    end
                end
                PH_SHIFT: res.chain_clock = 1'b1;
                default: res.chain_clock = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_FLUSH;
            flush_count_reg  <= '0;
            settle_count_reg <= '0;
            row_reg          <= '0;
            col_reg          <= '0;
            acc_reg          <= '0;
            any_change_reg   <= 1'b0;
            for (int i = 0; i < ROWS; i++) begin
                stored_reg[i] <= '0;
            end
        end else if (step) begin
            phase_reg        <= phase_next;
            flush_count_reg  <= flush_count_next;
            settle_count_reg <= settle_count_next;
            row_reg          <= row_next;
            col_reg          <= col_next;
            acc_reg          <= acc_next;
            any_change_reg   <= any_change_next;
            if (store_we) begin
                stored_reg[row_reg] <= acc_sampled;
            end
        end
    end

endmodule

/* rtl/wbkcs_out_buf.sv */
module wbkcs_out_buf
    import wbkcs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    push_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    head_valid_reg, head_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t head_reg, head_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop        = head_valid_reg & out_ready;
    assign push_ready = ~skid_valid_reg;
    assign out_valid  = head_valid_reg;
    assign out_data   = head_reg;

    always_comb begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (!head_valid_reg || pop) begin
            if (skid_valid_reg) begin
                // Promote the parked result; park the new one behind it
                head_next       = skid_reg;
                head_valid_next = 1'b1;
                skid_valid_next = push;
                skid_next       = push_data;
            end else begin
                head_valid_next = push;
                head_next       = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule
